// ===== hdl/mvt_pkg.sv =====
// mvt_pkg: shared constants and the binary32 normalize/round function
// used by the multiplier and adder of the vertex transform unit.
// No dependencies.
package mvt_pkg;

  localparam int unsigned FpW      = 32;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned NumCfg   = 8;
  localparam int unsigned SigW     = 48;

  localparam logic [FpW-1:0] QNAN   = 32'h7FC0_0000;
  localparam logic [7:0]     EXPMAX = 8'hFF;

  typedef logic [FpW-1:0] fp_t;
  typedef logic [CfgDataW-1:0] cfg_word_t;

  // sig bit 47 carries weight 2^(er-127); result rounded to nearest even
  function automatic fp_t fp_norm_round(input logic s, input logic signed [11:0] er,
                                        input logic [SigW-1:0] sig);
    logic [5:0]         lz;
    logic               found;
    logic [SigW-1:0]    w;
    logic               st;
    logic signed [11:0] e;
    logic signed [11:0] tmp;
    logic [11:0]        rs;
    logic [7:0]         ef;
    logic [30:0]        base;
    logic               up;
    lz    = '0;
    found = 1'b0;
    for (int i = SigW - 1; i >= 0; i--) begin
      if (!found) begin
        if (sig[i]) found = 1'b1;
        else        lz = lz + 6'd1;
      end
    end
    st  = 1'b0;
    tmp = er - 12'sd1;
    rs  = 12'(12'sd1 - er);
    if (er - $signed({6'b0, lz}) >= 12'sd1) begin
      w = sig << lz;
      e = er - $signed({6'b0, lz});
    end else if (er >= 12'sd1) begin
      // subnormal result, partial normalization only
      w = sig << tmp[5:0];
      e = 12'sd1;
    end else begin
      if (rs > 12'd47) begin
        w  = '0;
        st = |sig;
      end else begin
        w  = sig >> rs[5:0];
        st = |(sig & ~({SigW{1'b1}} << rs[5:0]));
      end
      e = 12'sd1;
    end
    if (e > 12'sd254) return {s, EXPMAX, 23'd0};
    ef   = w[47] ? e[7:0] : 8'd0;
    base = {ef, w[46:24]};
    up   = w[23] & (st | (|w[22:0]) | w[24]);
    // carry out of the fraction moves into the exponent, up to infinity
    return {s, base + 31'(up)};
  endfunction

endpackage

// ===== hdl/matrix4_vector4_transform.sv =====
// matrix4_vector4_transform: 4x4 binary32 matrix times 4-vector, pipelined.
// Depends on mvt_pkg, mvt_fmul, mvt_fadd.
//
// Takes one vector per clock while the pipeline is not stalled, and returns
// each transformed vector after two stages of multiply, then three chained
// three-stage adds per row. out_stall freezes the whole pipeline while a
// result waits at the output, and in_stall follows it. The matrix is
// held column-major in eight 64-bit registers (identity after reset); the
// user must write it only while no transaction is in flight, and the block
// itself does not enforce this. NaN results come out as 0x7FC00000.
module matrix4_vector4_transform (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mvt_pkg::CfgIdxW-1:0]   cfg_index,
  input  mvt_pkg::cfg_word_t            cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mvt_pkg::fp_t                  in_x,
  input  mvt_pkg::fp_t                  in_y,
  input  mvt_pkg::fp_t                  in_z,
  input  mvt_pkg::fp_t                  in_w,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mvt_pkg::fp_t                  out_x,
  output mvt_pkg::fp_t                  out_y,
  output mvt_pkg::fp_t                  out_z,
  output mvt_pkg::fp_t                  out_w
);
  import mvt_pkg::*;

  localparam int unsigned Lat    = 11;
  localparam int unsigned AddLat = 3;

  cfg_word_t      cfg_r [NumCfg];
  logic [Lat-1:0] vld_r;
  logic [Lat-1:0] vld_nxt;
  logic           en;
  fp_t            vin [4];
  fp_t            res [4];

  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;
  assign vin[3] = in_w;

  assign en       = ~(vld_r[Lat-1] & out_stall);
  assign in_stall = ~en;
  assign vld_nxt  = {vld_r[Lat-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= 64'h0000_0000_3F80_0000;
      cfg_r[1] <= '0;
      cfg_r[2] <= 64'h3F80_0000_0000_0000;
      cfg_r[3] <= '0;
      cfg_r[4] <= '0;
      cfg_r[5] <= 64'h0000_0000_3F80_0000;
      cfg_r[6] <= '0;
      cfg_r[7] <= 64'h3F80_0000_0000_0000;
      vld_r    <= '0;
    end else begin
      if (cfg_we && (cfg_index < CfgIdxW'(NumCfg))) begin
        cfg_r[cfg_index[2:0]] <= cfg_wdata;
      end
      if (en) vld_r <= vld_nxt;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    fp_t prod [4];
    fp_t s01, s012;
    fp_t p2_dly_r [AddLat];
    fp_t p3_dly_r [2*AddLat];

    for (genvar c = 0; c < 4; c++) begin : g_col
      mvt_fmul u_mul (
        .clk (clk),
        .en  (en),
        .a   (cfg_r[c*2 + r/2][(r%2)*FpW +: FpW]),
        .b   (vin[c]),
        .y   (prod[c])
      );
    end

    // later products wait for the running sum
    always_ff @(posedge clk) begin
      if (en) begin
        p2_dly_r[0] <= prod[2];
        for (int i = 1; i < AddLat; i++) p2_dly_r[i] <= p2_dly_r[i-1];
        p3_dly_r[0] <= prod[3];
        for (int i = 1; i < 2*AddLat; i++) p3_dly_r[i] <= p3_dly_r[i-1];
      end
    end

    mvt_fadd u_add0 (.clk(clk), .en(en), .a(prod[0]), .b(prod[1]), .y(s01));
    mvt_fadd u_add1 (.clk(clk), .en(en), .a(s01), .b(p2_dly_r[AddLat-1]), .y(s012));
    mvt_fadd u_add2 (.clk(clk), .en(en), .a(s012), .b(p3_dly_r[2*AddLat-1]), .y(res[r]));
  end

  assign out_valid = vld_r[Lat-1];
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_w     = res[3];

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_frozen_valids : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  a_canon_nan : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_x[30:23] == EXPMAX) && (out_x[22:0] != '0) && (out_x != QNAN)))
    else $error("non-canonical nan on out_x");

  a_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !vld_r[Lat-2]) |=> !out_valid)
    else $error("result repeated after its transaction");

endmodule

// ===== hdl/mvt_fmul.sv =====
// mvt_fmul: two-stage binary32 multiplier, round to nearest even.
// Depends on mvt_pkg.
module mvt_fmul (
  input  logic          clk,
  input  logic          en,
  input  mvt_pkg::fp_t  a,
  input  mvt_pkg::fp_t  b,
  output mvt_pkg::fp_t  y
);
  import mvt_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;

  logic               sign_r, nan_r, inf_r;
  logic signed [11:0] exp_r;
  logic [SigW-1:0]    prod_r;
  fp_t                y_r;
  fp_t                y_nxt;

  always_comb begin
    a_nan  = (a[30:23] == EXPMAX) && (a[22:0] != '0);
    b_nan  = (b[30:23] == EXPMAX) && (b[22:0] != '0);
    a_inf  = (a[30:23] == EXPMAX) && (a[22:0] == '0);
    b_inf  = (b[30:23] == EXPMAX) && (b[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    ma     = {a[30:23] != '0, a[22:0]};
    mb     = {b[30:23] != '0, b[22:0]};
    ea     = (a[30:23] == '0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == '0) ? 8'd1 : b[30:23];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign_r <= a[31] ^ b[31];
      nan_r  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      inf_r  <= a_inf | b_inf;
      exp_r  <= $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd126;
      prod_r <= ma * mb;
      y_r    <= y_nxt;
    end
  end

  always_comb begin
    if (nan_r)             y_nxt = QNAN;
    else if (inf_r)        y_nxt = {sign_r, EXPMAX, 23'd0};
    else if (prod_r == '0) y_nxt = {sign_r, 31'd0};
    else                   y_nxt = fp_norm_round(sign_r, exp_r, prod_r);
  end

  assign y = y_r;

endmodule

// ===== hdl/mvt_fadd.sv =====
// mvt_fadd: three-stage binary32 adder (align, add, normalize and round).
// Depends on mvt_pkg.
module mvt_fadd (
  input  logic          clk,
  input  logic          en,
  input  mvt_pkg::fp_t  a,
  input  mvt_pkg::fp_t  b,
  output mvt_pkg::fp_t  y
);
  import mvt_pkg::*;

  logic            swap;
  fp_t             big, sml;
  logic            a_nan, b_nan, a_inf, b_inf;
  logic [7:0]      eb, es, d;
  logic [SigW-1:0] sml_sig, sml_al;
  logic            sml_st;
  logic            spec;
  fp_t             spec_val;

  // stage 1 registers
  logic               sub1_r, sign1_r, spec1_r;
  fp_t                spec1_val_r;
  logic signed [11:0] exp1_r;
  logic [SigW-1:0]    big1_r, sml1_r;
  // stage 2 registers
  logic               sign2_r, zsign2_r, spec2_r;
  fp_t                spec2_val_r;
  logic signed [11:0] exp2_r;
  logic [SigW-1:0]    sum2_r;
  // stage 3
  fp_t                y_r;
  fp_t                y_nxt;

  always_comb begin
    a_nan = (a[30:23] == EXPMAX) && (a[22:0] != '0);
    b_nan = (b[30:23] == EXPMAX) && (b[22:0] != '0);
    a_inf = (a[30:23] == EXPMAX) && (a[22:0] == '0);
    b_inf = (b[30:23] == EXPMAX) && (b[22:0] == '0);
    swap  = b[30:0] > a[30:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    eb    = (big[30:23] == '0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    d     = eb - es;
    sml_sig = {1'b0, sml[30:23] != '0, sml[22:0], 23'd0};
    if (d >= 8'd48) begin
      sml_al = '0;
      sml_st = |sml_sig;
    end else begin
      sml_al = sml_sig >> d[5:0];
      sml_st = |(sml_sig & ~({SigW{1'b1}} << d[5:0]));
    end
    spec     = 1'b0;
    spec_val = QNAN;
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      spec = 1'b1;
    end else if (a_inf || b_inf) begin
      spec     = 1'b1;
      spec_val = {a_inf ? a[31] : b[31], EXPMAX, 23'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sub1_r      <= a[31] ^ b[31];
      sign1_r     <= big[31];
      spec1_r     <= spec;
      spec1_val_r <= spec_val;
      exp1_r      <= $signed({4'b0, eb}) + 12'sd1;
      big1_r      <= {1'b0, big[30:23] != '0, big[22:0], 23'd0};
      // shifted-out bits jam into the lsb
      sml1_r      <= {sml_al[SigW-1:1], sml_al[0] | sml_st};

      sign2_r     <= sign1_r;
      zsign2_r    <= sign1_r & ~sub1_r;
      spec2_r     <= spec1_r;
      spec2_val_r <= spec1_val_r;
      exp2_r      <= exp1_r;
      sum2_r      <= sub1_r ? (big1_r - sml1_r) : (big1_r + sml1_r);

      y_r         <= y_nxt;
    end
  end

  always_comb begin
    if (spec2_r)           y_nxt = spec2_val_r;
    else if (sum2_r == '0) y_nxt = {zsign2_r, 31'd0};
    else                   y_nxt = fp_norm_round(sign2_r, exp2_r, sum2_r);
  end

  assign y = y_r;

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for matrix4_vector4_transform.
// Predicts each transformed vector with a bit-exact binary32 model and
// checks results in order. Depends on mvt_pkg and the transform RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mvt_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 30;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  cfg_word_t cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  fp_t       in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  fp_t       out_x, out_y, out_z, out_w;

  typedef struct packed {
    fp_t x;
    fp_t y;
    fp_t z;
    fp_t w;
  } vec4_t;

  class vertex_scoreboard;
    cfg_word_t mat_regs[NumCfg];
    vec4_t     expected_q[$];
    int        errors;

    function new();
      errors = 0;
      mat_regs[0] = 64'h0000_0000_3F80_0000;
      mat_regs[1] = '0;
      mat_regs[2] = 64'h3F80_0000_0000_0000;
      mat_regs[3] = '0;
      mat_regs[4] = '0;
      mat_regs[5] = 64'h0000_0000_3F80_0000;
      mat_regs[6] = '0;
      mat_regs[7] = 64'h3F80_0000_0000_0000;
    endfunction

    function void write_reg(int unsigned idx, cfg_word_t val);
      if (idx < NumCfg) mat_regs[idx] = val;
    endfunction

    function bit [31:0] elem(int unsigned col, int unsigned row);
      cfg_word_t r;
      r = mat_regs[col * 2 + row / 2];
      return (row % 2) ? r[63:32] : r[31:0];
    endfunction

    function bit is_nan(bit [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 0);
    endfunction

    function bit is_inf(bit [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] == 0);
    endfunction

    function void unpack(bit [31:0] b, output bit [127:0] m, output int e);
      if (b[30:23] == 0) begin
        m = {105'd0, b[22:0]};
        e = -149;
      end else begin
        m = {104'd0, 1'b1, b[22:0]};
        e = int'(b[30:23]) - 150;
      end
    endfunction

    // value is m * 2^e, rounded to nearest even into binary32
    function bit [31:0] round_pack(bit s, bit [127:0] m, int e);
      int        p;
      int        sh;
      int        q;
      bit [127:0] keep;
      bit [127:0] rem;
      bit [127:0] half;
      bit        sticky;
      int        biased;
      p = 0;
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      sh = p - 23;
      if (-149 - e > sh) sh = -149 - e;
      q = e + sh;
      if (sh <= 0) begin
        keep = m << (-sh);
      end else begin
        sticky = 1'b0;
        // fold far-away bits into a sticky bit below the round position
        while (sh > 65) begin
          sticky = sticky | (m[63:0] != 0);
          m = m >> 64;
          sh = sh - 64;
        end
        m[0] = m[0] | sticky;
        rem  = m & ((128'd1 << sh) - 1);
        half = 128'd1 << (sh - 1);
        keep = m >> sh;
        if (rem > half || (rem == half && keep[0])) keep = keep + 1;
      end
      if (keep >= (128'd1 << 24)) begin
        keep = keep >> 1;
        q = q + 1;
      end
      if (keep < (128'd1 << 23)) return {s, 8'd0, keep[22:0]};
      biased = q + 150;
      if (biased >= 255) return {s, 8'hFF, 23'd0};
      return {s, biased[7:0], keep[22:0]};
    endfunction

    function bit [31:0] fp_mul(bit [31:0] a, bit [31:0] b);
      bit [127:0] ma, mb;
      int ea, eb;
      bit s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return QNAN;
      if (is_inf(a) || is_inf(b)) begin
        if (a[30:0] == 0 || b[30:0] == 0) return QNAN;
        return {s, 8'hFF, 23'd0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      return round_pack(s, ma * mb, ea + eb);
    endfunction

    function bit [31:0] fp_add(bit [31:0] a, bit [31:0] b);
      bit [127:0] ma, mb, big, lit, sh_lit, mag;
      int ea, eb, eb_big, d;
      bit sa, sb, s;
      if (is_nan(a) || is_nan(b)) return QNAN;
      if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      if (ea >= eb) begin
        big = ma << 40; lit = mb << 40; eb_big = ea; d = ea - eb; sa = a[31]; sb = b[31];
      end else begin
        big = mb << 40; lit = ma << 40; eb_big = eb; d = eb - ea; sa = b[31]; sb = a[31];
      end
      if (d >= 100) begin
        sh_lit = (lit != 0);
      end else begin
        sh_lit = lit >> d;
        if ((sh_lit << d) != lit) sh_lit[0] = 1'b1;
      end
      if (sa == sb) begin
        mag = big + sh_lit; s = sa;
      end else if (big >= sh_lit) begin
        mag = big - sh_lit; s = sa;
      end else begin
        mag = sh_lit - big; s = sb;
      end
      if (mag == 0) return 32'd0;
      return round_pack(s, mag, eb_big - 40);
    endfunction

    function bit [31:0] row_result(int unsigned row, vec4_t v);
      bit [31:0] acc;
      acc = fp_add(fp_mul(elem(0, row), v.x), fp_mul(elem(1, row), v.y));
      acc = fp_add(acc, fp_mul(elem(2, row), v.z));
      acc = fp_add(acc, fp_mul(elem(3, row), v.w));
      return is_nan(acc) ? QNAN : acc;
    endfunction

    function void note_input(vec4_t v);
      vec4_t r;
      r.x = row_result(0, v);
      r.y = row_result(1, v);
      r.z = row_result(2, v);
      r.w = row_result(3, v);
      expected_q.push_back(r);
    endfunction

    function void check_result(vec4_t got);
      vec4_t exp_v;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      if (got.x !== exp_v.x) begin
        $display("%0t: out_x expected %h actual %h", $realtime, exp_v.x, got.x); errors++;
      end
      if (got.y !== exp_v.y) begin
        $display("%0t: out_y expected %h actual %h", $realtime, exp_v.y, got.y); errors++;
      end
      if (got.z !== exp_v.z) begin
        $display("%0t: out_z expected %h actual %h", $realtime, exp_v.z, got.z); errors++;
      end
      if (got.w !== exp_v.w) begin
        $display("%0t: out_w expected %h actual %h", $realtime, exp_v.w, got.w); errors++;
      end
    endfunction
  endclass

  vertex_scoreboard sb = new();
  int unsigned cycles = 0;
  bit long_hold_req = 1'b0;

  matrix4_vector4_transform dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // transaction monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input('{in_x, in_y, in_z, in_w});
    if (rst_n && out_valid && !out_stall) sb.check_result('{out_x, out_y, out_z, out_w});
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold;
    if (hold > 0) begin
      out_stall <= 1'b1;
      hold = hold - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold = 300;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 200);
      end
      mode_left = mode_left - 1;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= $urandom_range(0, 1);
      endcase
    end
  end

  function automatic fp_t rand_fp();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h7F80_0000 : 32'hFF80_0000;
      3: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      4: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())};
      5: return {$urandom_range(0, 1) == 1, 8'hFE, 23'($urandom())};
      6, 7: return $urandom();
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(112, 142)), 23'($urandom())};
    endcase
  endfunction

  // one write, then the enable goes low before the task returns
  task automatic write_cfg(int unsigned idx, cfg_word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx[CfgIdxW-1:0];
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_vec(fp_t x, fp_t y, fp_t z, fp_t w);
    in_valid <= 1'b1;
    in_x <= x; in_y <= y; in_z <= z; in_w <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int unsigned n);
    int unsigned left;
    int unsigned burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && left > 0) begin
        send_vec(rand_fp(), rand_fp(), rand_fp(), rand_fp());
        burst--;
        left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity matrix after reset, driven with special and extreme inputs
    send_vec(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001);
    send_vec(32'h7F80_0000, 32'hFF80_0000, 32'h7FFF_FFFF, 32'hFFC0_1234);
    send_vec(32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h3F80_0000);
    send_vec(32'h007F_FFFF, 32'h0080_0000, 32'h8080_0000, 32'h807F_FFFF);
    in_valid <= 1'b0;
    wait_idle();

    // all twos: overflow, inf-inf, cancellation, subnormals
    for (int i = 0; i < NumCfg; i++) write_cfg(i, 64'h4000_0000_4000_0000);
    send_vec(32'h7F7F_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_vec(32'h3F80_0000, 32'hBF80_0000, 32'h0000_0001, 32'h8000_0001);
    send_vec(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'hFF7F_FFFF);
    in_valid <= 1'b0;
    wait_idle();

    // extremes: half-min subnormal, infinities, zeros, all ones
    write_cfg(0, 64'h3F00_0000_0000_0001);
    write_cfg(1, 64'h7F80_0000_8000_0000);
    write_cfg(2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(3, 64'h0000_0000_0000_0000);
    write_cfg(4, 64'h7F7F_FFFF_0080_0000);
    write_cfg(5, 64'hFF80_0000_3F80_0000);
    write_cfg(6, 64'h0000_0001_BF80_0000);
    write_cfg(7, 64'h7FC0_0000_3400_0000);
    // indexes past the last register are dropped
    write_cfg(8, 64'h1234_5678_9ABC_DEF0);
    write_cfg(255, '0);
    send_vec(32'h0000_0001, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000);
    send_vec(32'h3F80_0001, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000);
    send_vec(32'h0000_0000, 32'h0000_0000, 32'h3F80_0000, 32'h0000_0000);
    send_vec(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000);
    in_valid <= 1'b0;
    wait_idle();

    // random matrices of specials, moderate values and raw bits
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NumCfg; i++) write_cfg(i, {rand_fp(), rand_fp()});
      if ($urandom_range(0, 1)) write_cfg($urandom_range(NumCfg, 255), {$urandom(), $urandom()});
      if (ph == 2) long_hold_req = 1'b1;
      send_random(200);
      wait_idle();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
